// ----- design/rvd_pkg.sv -----
`default_nettype none

package rvd_pkg;

    localparam int IN_W   = 32;
    localparam int DATA_W = 56;
    localparam int USER_W = 4;

    typedef enum logic [2:0] {
        FMT_R    = 3'd0,
        FMT_I    = 3'd1,
        FMT_S    = 3'd2,
        FMT_B    = 3'd3,
        FMT_U    = 3'd4,
        FMT_J    = 3'd5,
        FMT_NONE = 3'd6
    } t_fmt;

    typedef enum logic [5:0] {
        M_ADD, M_SUB, M_SLL, M_SLT, M_SLTU, M_XOR, M_SRL, M_SRA, M_OR, M_AND,
        M_JALR, M_LB, M_LH, M_LW, M_LBU, M_LHU,
        M_ADDI, M_SLLI, M_SLTI, M_SLTIU, M_XORI, M_SRLI, M_SRAI, M_ORI, M_ANDI,
        M_FENCE, M_FENCE_I, M_ECALL, M_EBREAK,
        M_CSRRW, M_CSRRS, M_CSRRC, M_CSRRWI, M_CSRRSI, M_CSRRCI,
        M_SB, M_SH, M_SW,
        M_BEQ, M_BNE, M_BLT, M_BGE, M_BLTU, M_BGEU,
        M_LUI, M_AUIPC, M_JAL
    } t_mnem;

    localparam logic [6:0] OP_LUI    = 7'h37;
    localparam logic [6:0] OP_AUIPC  = 7'h17;
    localparam logic [6:0] OP_JAL    = 7'h6f;
    localparam logic [6:0] OP_JALR   = 7'h67;
    localparam logic [6:0] OP_BRANCH = 7'h63;
    localparam logic [6:0] OP_LOAD   = 7'h03;
    localparam logic [6:0] OP_STORE  = 7'h23;
    localparam logic [6:0] OP_IMM    = 7'h13;
    localparam logic [6:0] OP_REG    = 7'h33;
    localparam logic [6:0] OP_FENCE  = 7'h0f;
    localparam logic [6:0] OP_SYSTEM = 7'h73;

    localparam logic [2:0] F3_ADDSUB  = 3'd0;
    localparam logic [2:0] F3_SHR     = 3'd5;
    localparam logic [2:0] F3_PRIV    = 3'd0;
    localparam logic [2:0] F3_FENCE   = 3'd0;
    localparam logic [2:0] F3_FENCE_I = 3'd1;

    // funct3-indexed tables; an entry whose bit in the *_OK mask is clear is unused
    localparam t_mnem R_TAB [8] = '{M_ADD, M_SLL, M_SLT, M_SLTU, M_XOR, M_SRL, M_OR, M_AND};
    localparam t_mnem I_TAB [8] = '{M_ADDI, M_SLLI, M_SLTI, M_SLTIU, M_XORI, M_SRLI,
                                    M_ORI, M_ANDI};
    localparam t_mnem L_TAB [8] = '{M_LB, M_LH, M_LW, M_ADD, M_LBU, M_LHU, M_ADD, M_ADD};
    localparam t_mnem C_TAB [8] = '{M_ECALL, M_CSRRW, M_CSRRS, M_CSRRC, M_ADD,
                                    M_CSRRWI, M_CSRRSI, M_CSRRCI};
    localparam t_mnem S_TAB [8] = '{M_SB, M_SH, M_SW, M_ADD, M_ADD, M_ADD, M_ADD, M_ADD};
    localparam t_mnem B_TAB [8] = '{M_BEQ, M_BNE, M_ADD, M_ADD, M_BLT, M_BGE, M_BLTU,
                                    M_BGEU};
    localparam logic [7:0] L_OK = 8'b0011_0111;
    localparam logic [7:0] C_OK = 8'b1110_1111;
    localparam logic [7:0] S_OK = 8'b0000_0111;
    localparam logic [7:0] B_OK = 8'b1111_0011;

    typedef struct packed {
        logic         known;
        t_mnem        mnemonic;
        t_fmt         insn_format;
        logic [4:0]   first_reg;
        logic [4:0]   second_reg;
        logic [20:0]  second_imm;
        logic [4:0]   third_reg;
        logic [12:0]  third_imm;
    } t_dec_result;

endpackage

`default_nettype wire

// ----- design/rvd_decode.sv -----
`default_nettype none

module rvd_decode
    import rvd_pkg::*;
(
    input  wire logic [IN_W-1:0] i_insn_word,
    output t_dec_result          o_result
);

    logic [6:0] op;
    logic [2:0] f3;
    logic       f7nz;
    logic       rs2nz;
    logic [4:0] rd;
    logic [4:0] rs1;
    logic [4:0] rs2;
    logic       sgn;
    t_fmt       fmt;
    t_mnem      mn;
    logic       ok;

    assign op    = i_insn_word[6:0];
    assign f3    = i_insn_word[14:12];
    assign f7nz  = |i_insn_word[31:25];
    assign rs2nz = |i_insn_word[24:20];
    assign rd    = i_insn_word[11:7];
    assign rs1   = i_insn_word[19:15];
    assign rs2   = i_insn_word[24:20];
    assign sgn   = i_insn_word[31];

    always_comb begin
        unique case (op) inside
            OP_LUI, OP_AUIPC: fmt = FMT_U;
            OP_JAL: fmt = FMT_J;
            OP_JALR, OP_LOAD, OP_IMM, OP_FENCE, OP_SYSTEM: fmt = FMT_I;
            OP_BRANCH: fmt = FMT_B;
            OP_STORE: fmt = FMT_S;
            OP_REG: fmt = FMT_R;
            default: fmt = FMT_NONE;
        endcase
    end

    always_comb begin
        mn = M_ADD;
        ok = 1'b1;
        unique case (op)
            OP_REG: begin
                if ((f3 == F3_ADDSUB) && f7nz) begin
                    mn = M_SUB;
                end else if ((f3 == F3_SHR) && f7nz) begin
                    mn = M_SRA;
                end else begin
                    mn = R_TAB[f3];
                end
            end
            OP_JALR: mn = M_JALR;
            OP_LOAD: begin
                mn = L_TAB[f3];
                ok = L_OK[f3];
            end
            OP_IMM: begin
                mn = ((f3 == F3_SHR) && f7nz) ? M_SRAI : I_TAB[f3];
            end
            OP_FENCE: begin
                if (f3 == F3_FENCE) begin
                    mn = M_FENCE;
                end else if (f3 == F3_FENCE_I) begin
                    mn = M_FENCE_I;
                end else begin
                    ok = 1'b0;
                end
            end
            OP_SYSTEM: begin
                // any nonzero rs2 field reads as ebreak
                if (f3 == F3_PRIV) begin
                    mn = rs2nz ? M_EBREAK : M_ECALL;
                end else begin
                    mn = C_TAB[f3];
                    ok = C_OK[f3];
                end
            end
            OP_STORE: begin
                mn = S_TAB[f3];
                ok = S_OK[f3];
            end
            OP_BRANCH: begin
                mn = B_TAB[f3];
                ok = B_OK[f3];
            end
            OP_LUI:   mn = M_LUI;
            OP_AUIPC: mn = M_AUIPC;
            OP_JAL:   mn = M_JAL;
            default:  ok = 1'b0;
        endcase
    end

    always_comb begin
        o_result             = '0;
        o_result.known       = ok;
        o_result.mnemonic    = ok ? mn : M_ADD;
        o_result.insn_format = fmt;
        unique case (fmt)
            FMT_R: begin
                o_result.first_reg  = rd;
                o_result.second_reg = rs1;
                o_result.third_reg  = rs2;
            end
            FMT_I: begin
                o_result.first_reg  = rd;
                o_result.second_reg = rs1;
                o_result.third_imm  = {sgn, i_insn_word[31:20]};
            end
            FMT_S: begin
                o_result.first_reg  = rs2;
                o_result.second_reg = rs1;
                o_result.third_imm  = {sgn, i_insn_word[31:25], i_insn_word[11:7]};
            end
            FMT_B: begin
                o_result.first_reg  = rs1;
                o_result.second_reg = rs2;
                o_result.third_imm  = {sgn, i_insn_word[7], i_insn_word[30:25],
                                       i_insn_word[11:8], 1'b0};
            end
            FMT_U: begin
                o_result.first_reg  = rd;
                o_result.second_imm = {1'b0, i_insn_word[31:12]};
            end
            FMT_J: begin
                o_result.first_reg  = rd;
                o_result.second_imm = {sgn, i_insn_word[19:12], i_insn_word[20],
                                       i_insn_word[30:21], 1'b0};
            end
            default: begin
                o_result.known    = 1'b0;
                o_result.mnemonic = M_ADD;
            end
        endcase
    end

endmodule

`default_nettype wire

// ----- design/rv32i_instruction_decoder_core.sv -----
`default_nettype none

// RV32I instruction decoder. Takes one instruction word per cycle on s_axis
// while s_axis_tready is high and returns one decoded item per word on m_axis,
// in order. An item passes an input register and a result register; sustained
// rate one item per cycle while m_axis_tready is high, set by the single decode
// pass between the two registers. While a result waits on a stalled m_axis_tready
// the input register takes one more item, then s_axis_tready stays low until
// m_axis moves; s_axis_tready follows m_axis_tready combinationally.
module rv32i_instruction_decoder_core
    import rvd_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              s_axis_tvalid,
    output logic                   s_axis_tready,
    input  wire logic [IN_W-1:0]   s_axis_tdata,   // [31:0] insn_word
    output logic                   m_axis_tvalid,
    input  wire logic              m_axis_tready,
    // [5:0] mnemonic, [10:6] first_reg, [15:11] second_reg, [36:16] second_imm,
    // [41:37] third_reg, [54:42] third_imm, [55] zero
    output logic [DATA_W-1:0]      m_axis_tdata,
    output logic [USER_W-1:0]      m_axis_tuser    // [0] known, [3:1] insn_format
);

    logic              r_in_valid;
    logic [IN_W-1:0]   r_in_word;
    logic              r_out_valid;
    t_dec_result       r_out;
    t_dec_result       dec;
    logic              out_load;

    assign out_load      = !r_out_valid || m_axis_tready;
    assign s_axis_tready = !r_in_valid || out_load;

    rvd_decode u_decode (
        .i_insn_word (r_in_word),
        .o_result    (dec)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (s_axis_tready) begin
                r_in_valid <= s_axis_tvalid;
            end
            if (out_load) begin
                r_out_valid <= r_in_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tready && s_axis_tvalid) begin
            r_in_word <= s_axis_tdata;
        end
        if (out_load && r_in_valid) begin
            r_out <= dec;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {1'b0, r_out.third_imm, r_out.third_reg, r_out.second_imm,
                            r_out.second_reg, r_out.first_reg, r_out.mnemonic};
    assign m_axis_tuser  = {r_out.insn_format, r_out.known};

endmodule

`default_nettype wire
